// ----- rtl/alpr_pkg.sv -----
`timescale 1ns / 1ps

package alpr_pkg;

    // field widths of the item and result channels
    localparam int CMD_W    = 3;
    localparam int PIX_W    = 10;
    localparam int COLOUR_W = 8;
    localparam int BRIN_W   = 8;
    localparam int BRI_W    = 7;
    localparam int DUTY_W   = 8;
    localparam int SLOT_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam int RGB_W    = 3 * COLOUR_W;
    localparam int PROD_W   = COLOUR_W + BRI_W;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_COLOUR     = 3'd0,
        CMD_SET_BRIGHTNESS = 3'd1,
        CMD_READ_PIXEL     = 3'd2,
        CMD_START          = 3'd3,
        CMD_REFILL         = 3'd4
    } cmd_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_REFILLS = 1'b1;

    localparam logic [CFG_DATA_W-1:0] BIT_PERIOD_RST    = 8'd90;
    localparam logic [CFG_DATA_W-1:0] RESET_REFILLS_RST = 8'd50;

    // pixel store contents after reset
    localparam logic [RGB_W-1:0] RGB_RST = 24'hFF_FFFF;
    localparam logic [BRI_W-1:0] BRI_RST = 7'd50;
    localparam logic [BRIN_W-1:0] BRI_MAX = 8'd100;

    // x / 100 as (x * 5243) >> 19, exact for x below 43690
    localparam int RECIP_W = 28;
    localparam logic [RECIP_W-1:0] SCALE_RECIP = 28'd5243;
    localparam int SCALE_SHIFT = 19;

    // slots of one buffer half
    localparam logic [SLOT_W-1:0] FIRST_SLOT = 5'd0;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = 5'd23;

    localparam logic [PIX_W-1:0] PIXEL_FIRST      = 10'd0;
    localparam logic [PIX_W-1:0] PIXEL_SECOND     = 10'd1;
    localparam logic [PIX_W-1:0] START_NEXT_PIXEL = 10'd2;
    localparam logic [CFG_DATA_W-1:0] ZERO_HALVES = 8'd2;

    typedef enum logic [1:0] {
        COL_RED   = 2'd0,
        COL_GREEN = 2'd1,
        COL_BLUE  = 2'd2
    } colour_t;

    // payload of an item as the datapath sees it
    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic [BRIN_W-1:0]   brightness;
    } item_data_t;

    // one result
    typedef struct packed {
        logic                kind;
        logic [DUTY_W-1:0]   duty;
        logic                out_half;
        logic [SLOT_W-1:0]   slot;
        logic                last;
        logic [COLOUR_W-1:0] read_red;
        logic [COLOUR_W-1:0] read_green;
        logic [COLOUR_W-1:0] read_blue;
        logic [BRI_W-1:0]    read_brightness;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic              clr_en;
        logic              wr_colour;
        logic              wr_bright;
        logic              rd_en;
        logic [PIX_W-1:0]  addr;
        logic              mul_en;
        logic              div_en;
        colour_t           colour;
        logic              emit_word;
        logic              emit_zero;
        logic              emit_reply;
        logic              last;
        logic              half;
        logic [SLOT_W-1:0] slot;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic                  out_free;
        logic [CFG_DATA_W-1:0] reset_refills;
    } dp_status_t;

endpackage

// ----- rtl/alpr_if.sv -----
`timescale 1ns / 1ps

// command channel
interface alpr_item_if;
    import alpr_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PIX_W-1:0]    pixel_index;
    logic [COLOUR_W-1:0] red_in;
    logic [COLOUR_W-1:0] green_in;
    logic [COLOUR_W-1:0] blue_in;
    logic [BRIN_W-1:0]   brightness_in;
    logic                buffer_half;

    modport source (
        output valid, command, pixel_index, red_in, green_in, blue_in,
               brightness_in, buffer_half,
        input  ready
    );
    modport sink (
        input  valid, command, pixel_index, red_in, green_in, blue_in,
               brightness_in, buffer_half,
        output ready
    );
endinterface

// result channel
interface alpr_result_if;
    import alpr_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [DUTY_W-1:0]   duty;
    logic                out_half;
    logic [SLOT_W-1:0]   slot;
    logic                last;
    logic [COLOUR_W-1:0] read_red;
    logic [COLOUR_W-1:0] read_green;
    logic [COLOUR_W-1:0] read_blue;
    logic [BRI_W-1:0]    read_brightness;

    modport source (
        output valid, kind, duty, out_half, slot, last, read_red, read_green,
               read_blue, read_brightness,
        input  ready
    );
    modport sink (
        input  valid, kind, duty, out_half, slot, last, read_red, read_green,
               read_blue, read_brightness,
        output ready
    );
endinterface

// configuration write channel
interface alpr_cfg_if;
    import alpr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/addressable_led_pwm_refill_top.sv -----
`timescale 1ns / 1ps

// Addressable LED pulse-width refill block.
// item: command transfers (set colour, set brightness, read pixel, start,
// refill). result: duty words for the ping-pong buffer and read replies,
// with last set on the final result of each command. cfg: register writes
// (0 bit period, 1 reset refills), always ready, to be written while idle.
// Set commands give no result. A read gives one reply, launched once the
// output register is free. A refill that sends a pixel makes one store
// read, three multiply and divide pairs in the scaling unit, then 24 duty
// words at one a cycle while the receiver keeps up; start sends two pixels
// (48 words), a reset code half 24 zero words. The rate is set by
// the single shared scaling multiplier and the one-word output register.
// After reset the pixel store is cleared to white at brightness 50 in one
// pass over every pixel, during which item is not ready.
// A stalled result receiver holds the word sequence in place; nothing is
// dropped, and the next command is taken once the current one has
// launched its last result.
module addressable_led_pwm_refill_top #(
    parameter int PIXEL_COUNT = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    alpr_item_if.sink     item,
    alpr_result_if.source result,
    alpr_cfg_if.sink      cfg
);
    import alpr_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t status;
    item_data_t item_data;
    logic       in_ready;

    assign item_data.red        = item.red_in;
    assign item_data.green      = item.green_in;
    assign item_data.blue       = item.blue_in;
    assign item_data.brightness = item.brightness_in;
    assign item.ready           = in_ready;

    // sequencer
    alpr_ctrl #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .in_command (item.command),
        .in_index   (item.pixel_index),
        .in_half    (item.buffer_half),
        .in_ready   (in_ready),
        .status     (status),
        .dp_cmd     (dp_cmd)
    );

    // pixel store, scaling and output register
    alpr_datapath #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_data (item_data),
        .dp_cmd    (dp_cmd),
        .status    (status),
        .cfg       (cfg),
        .result    (result)
    );

endmodule

// ----- rtl/alpr_datapath.sv -----
`timescale 1ns / 1ps

module alpr_datapath #(
    parameter int PIXEL_COUNT = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alpr_pkg::item_data_t item_data,
    input  alpr_pkg::dp_cmd_t    dp_cmd,
    output alpr_pkg::dp_status_t status,
    alpr_cfg_if.sink             cfg,
    alpr_result_if.source        result
);
    import alpr_pkg::*;

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [PIX_W:0] PIX_LIMIT = (PIX_W + 1)'(PIXEL_COUNT);

    logic [RGB_W-1:0] rgb_mem [PIXEL_COUNT];
    logic [BRI_W-1:0] bri_mem [PIXEL_COUNT];

    logic [CFG_DATA_W-1:0] bit_period_reg;
    logic [CFG_DATA_W-1:0] reset_refills_reg;
    logic [RGB_W-1:0]      rgb_rd_reg;
    logic [BRI_W-1:0]      bri_rd_reg;
    logic                  rd_ok_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [RGB_W-1:0]      pix_bits_reg;
    out_item_t             out_reg;
    out_item_t             out_next;
    logic                  out_valid_reg;

    logic                  addr_ok;
    logic                  rgb_we;
    logic                  bri_we;
    logic [RGB_W-1:0]      rgb_wdata;
    logic [BRI_W-1:0]      bri_wdata;
    logic [AW-1:0]         mem_addr;
    logic [COLOUR_W-1:0]   colour_byte;
    logic [RECIP_W-1:0]    recip_prod;
    logic [COLOUR_W-1:0]   scaled;
    logic [9:0]            period_x3;
    logic [DUTY_W-1:0]     duty_hi;
    logic [DUTY_W-1:0]     duty_lo;
    logic                  cur_bit;
    logic                  emit;

    // store write and read control
    assign addr_ok   = ({1'b0, dp_cmd.addr} < PIX_LIMIT);
    assign mem_addr  = dp_cmd.addr[AW-1:0];
    assign rgb_we    = dp_cmd.clr_en | (dp_cmd.wr_colour & addr_ok);
    assign bri_we    = dp_cmd.clr_en
                     | (dp_cmd.wr_bright & addr_ok & (item_data.brightness <= BRI_MAX));
    assign rgb_wdata = dp_cmd.clr_en ? RGB_RST
                                     : {item_data.red, item_data.green, item_data.blue};
    assign bri_wdata = dp_cmd.clr_en ? BRI_RST : item_data.brightness[BRI_W-1:0];

    // pixel store
    always_ff @(posedge clk)
    begin
        if (rgb_we)
        begin
            rgb_mem[mem_addr] <= rgb_wdata;
        end
        if (bri_we)
        begin
            bri_mem[mem_addr] <= bri_wdata;
        end
        if (dp_cmd.rd_en)
        begin
            rgb_rd_reg <= rgb_mem[mem_addr];
            bri_rd_reg <= bri_mem[mem_addr];
        end
    end

    // colour select for the scaling multiplier
    always_comb
    begin
        case (dp_cmd.colour)
            COL_RED:   colour_byte = rgb_rd_reg[23:16];
            COL_GREEN: colour_byte = rgb_rd_reg[15:8];
            COL_BLUE:  colour_byte = rgb_rd_reg[7:0];
            default:   colour_byte = '0;
        endcase
    end

    // divide by 100 through the reciprocal
    assign recip_prod = RECIP_W'(prod_reg) * SCALE_RECIP;
    assign scaled     = recip_prod[SCALE_SHIFT +: COLOUR_W];

    // duty values for one and zero bits
    assign period_x3 = {2'b00, bit_period_reg} * 10'd3;
    assign duty_hi   = period_x3[9:2];
    assign duty_lo   = {2'b00, bit_period_reg[7:2]};
    assign cur_bit   = pix_bits_reg[LAST_SLOT - dp_cmd.slot];

    // next result
    always_comb
    begin
        out_next = '0;
        if (dp_cmd.emit_reply)
        begin
            out_next.kind = 1'b1;
            out_next.last = 1'b1;
            if (rd_ok_reg)
            begin
                out_next.read_red        = rgb_rd_reg[23:16];
                out_next.read_green      = rgb_rd_reg[15:8];
                out_next.read_blue       = rgb_rd_reg[7:0];
                out_next.read_brightness = bri_rd_reg;
            end
        end
        else
        begin
            out_next.duty     = dp_cmd.emit_zero ? '0 : (cur_bit ? duty_hi : duty_lo);
            out_next.out_half = dp_cmd.half;
            out_next.slot     = dp_cmd.slot;
            out_next.last     = dp_cmd.last;
        end
    end

    assign emit = dp_cmd.emit_word | dp_cmd.emit_zero | dp_cmd.emit_reply;

    // scaling pipeline and result payload
    always_ff @(posedge clk)
    begin
        if (dp_cmd.rd_en)
        begin
            rd_ok_reg <= addr_ok;
        end
        if (dp_cmd.mul_en)
        begin
            prod_reg <= PROD_W'(colour_byte) * PROD_W'(bri_rd_reg);
        end
        if (dp_cmd.div_en)
        begin
            case (dp_cmd.colour)
                COL_RED:   pix_bits_reg[23:16] <= scaled;
                COL_GREEN: pix_bits_reg[15:8]  <= scaled;
                COL_BLUE:  pix_bits_reg[7:0]   <= scaled;
                default:   ;
            endcase
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    // output valid and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            bit_period_reg    <= BIT_PERIOD_RST;
            reset_refills_reg <= RESET_REFILLS_RST;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_BIT_PERIOD:    bit_period_reg    <= cfg.data;
                    CFG_RESET_REFILLS: reset_refills_reg <= cfg.data;
                endcase
            end
        end
    end

    assign cfg.ready = 1'b1;

    assign status.out_free      = !out_valid_reg || result.ready;
    assign status.reset_refills = reset_refills_reg;

    assign result.valid           = out_valid_reg;
    assign result.kind            = out_reg.kind;
    assign result.duty            = out_reg.duty;
    assign result.out_half        = out_reg.out_half;
    assign result.slot            = out_reg.slot;
    assign result.last            = out_reg.last;
    assign result.read_red        = out_reg.read_red;
    assign result.read_green      = out_reg.read_green;
    assign result.read_blue       = out_reg.read_blue;
    assign result.read_brightness = out_reg.read_brightness;

endmodule

// ----- rtl/alpr_ctrl.sv -----
`timescale 1ns / 1ps

module alpr_ctrl #(
    parameter int PIXEL_COUNT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [alpr_pkg::CMD_W-1:0]    in_command,
    input  logic [alpr_pkg::PIX_W-1:0]    in_index,
    input  logic                          in_half,
    output logic                          in_ready,
    input  alpr_pkg::dp_status_t          status,
    output alpr_pkg::dp_cmd_t             dp_cmd
);
    import alpr_pkg::*;

    localparam logic [PIX_W:0] PIX_LIMIT = (PIX_W + 1)'(PIXEL_COUNT);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_REPLY = 8'b0000_0100,
        S_FETCH = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_ZERO  = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [PIX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [PIX_W-1:0]      next_pixel_reg, next_pixel_next;
    logic                  in_reset_code_reg, in_reset_code_next;
    logic [CFG_DATA_W-1:0] progress_reg, progress_next;
    logic                  last_half_reg, last_half_next;
    logic [PIX_W-1:0]      cur_pixel_reg, cur_pixel_next;
    logic                  cur_half_reg, cur_half_next;
    logic                  second_reg, second_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    colour_t               colour_reg, colour_next;

    logic [PIX_W:0]        pixel_inc;
    logic [CFG_DATA_W:0]   progress_inc;

    assign pixel_inc    = {1'b0, next_pixel_reg} + (PIX_W + 1)'(1);
    assign progress_inc = {1'b0, progress_reg} + (CFG_DATA_W + 1)'(1);

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        clr_cnt_next       = clr_cnt_reg;
        next_pixel_next    = next_pixel_reg;
        in_reset_code_next = in_reset_code_reg;
        progress_next      = progress_reg;
        last_half_next     = last_half_reg;
        cur_pixel_next     = cur_pixel_reg;
        cur_half_next      = cur_half_reg;
        second_next        = second_reg;
        slot_next          = slot_reg;
        colour_next        = colour_reg;
        dp_cmd             = '0;
        dp_cmd.colour      = colour_reg;
        dp_cmd.slot        = slot_reg;
        dp_cmd.half        = cur_half_reg;
        in_ready           = (state_reg == S_IDLE);

        unique case (state_reg)
            // clearing pass over the pixel store
            S_CLEAR:
            begin
                dp_cmd.clr_en = 1'b1;
                dp_cmd.addr   = clr_cnt_reg;
                if ({1'b0, clr_cnt_reg} == PIX_LIMIT - (PIX_W + 1)'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + PIX_W'(1);
                end
            end

            // command decode on transfer
            S_IDLE:
            begin
                dp_cmd.addr = in_index;
                if (in_valid)
                begin
                    unique case (cmd_t'(in_command))
                        CMD_SET_COLOUR:     dp_cmd.wr_colour = 1'b1;
                        CMD_SET_BRIGHTNESS: dp_cmd.wr_bright = 1'b1;
                        CMD_READ_PIXEL:
                        begin
                            dp_cmd.rd_en = 1'b1;
                            state_next   = S_REPLY;
                        end
                        CMD_START:
                        begin
                            next_pixel_next    = START_NEXT_PIXEL;
                            in_reset_code_next = 1'b0;
                            last_half_next     = 1'b1;
                            cur_pixel_next     = PIXEL_FIRST;
                            cur_half_next      = 1'b0;
                            second_next        = 1'b1;
                            state_next         = S_FETCH;
                        end
                        CMD_REFILL:
                        begin
                            if (in_half != last_half_reg)
                            begin
                                last_half_next = in_half;
                                cur_half_next  = in_half;
                                second_next    = 1'b0;
                                slot_next      = FIRST_SLOT;
                                if (!in_reset_code_reg)
                                begin
                                    cur_pixel_next  = next_pixel_reg;
                                    next_pixel_next = pixel_inc[PIX_W-1:0];
                                    state_next      = S_FETCH;
                                    if (pixel_inc >= PIX_LIMIT)
                                    begin
                                        in_reset_code_next = 1'b1;
                                        progress_next      = '0;
                                    end
                                end
                                else
                                begin
                                    if (progress_reg < ZERO_HALVES)
                                    begin
                                        state_next = S_ZERO;
                                    end
                                    progress_next = progress_inc[CFG_DATA_W-1:0];
                                    if (progress_inc >= {1'b0, status.reset_refills})
                                    begin
                                        next_pixel_next    = PIXEL_FIRST;
                                        in_reset_code_next = 1'b0;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // read reply
            S_REPLY:
            begin
                if (status.out_free)
                begin
                    dp_cmd.emit_reply = 1'b1;
                    dp_cmd.last       = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            // fetch pixel, then scale the three colours
            S_FETCH:
            begin
                dp_cmd.rd_en = 1'b1;
                dp_cmd.addr  = cur_pixel_reg;
                colour_next  = COL_RED;
                state_next   = S_MUL;
            end

            S_MUL:
            begin
                dp_cmd.mul_en = 1'b1;
                state_next    = S_DIV;
            end

            S_DIV:
            begin
                dp_cmd.div_en = 1'b1;
                if (colour_reg == COL_BLUE)
                begin
                    slot_next  = FIRST_SLOT;
                    state_next = S_EMIT;
                end
                else
                begin
                    colour_next = colour_t'(colour_reg + 2'd1);
                    state_next  = S_MUL;
                end
            end

            // 24 duty words of one pixel
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    dp_cmd.emit_word = 1'b1;
                    dp_cmd.last      = (slot_reg == LAST_SLOT) && !second_reg;
                    if (slot_reg == LAST_SLOT)
                    begin
                        if (second_reg)
                        begin
                            second_next    = 1'b0;
                            cur_pixel_next = PIXEL_SECOND;
                            cur_half_next  = 1'b1;
                            state_next     = S_FETCH;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end

            // 24 zero words of the reset code
            S_ZERO:
            begin
                if (status.out_free)
                begin
                    dp_cmd.emit_zero = 1'b1;
                    dp_cmd.last      = (slot_reg == LAST_SLOT);
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_cnt_reg       <= '0;
            next_pixel_reg    <= START_NEXT_PIXEL;
            in_reset_code_reg <= 1'b0;
            progress_reg      <= '0;
            last_half_reg     <= 1'b1;
            cur_pixel_reg     <= '0;
            cur_half_reg      <= 1'b0;
            second_reg        <= 1'b0;
            slot_reg          <= '0;
            colour_reg        <= COL_RED;
        end
        else
        begin
            state_reg         <= state_next;
            clr_cnt_reg       <= clr_cnt_next;
            next_pixel_reg    <= next_pixel_next;
            in_reset_code_reg <= in_reset_code_next;
            progress_reg      <= progress_next;
            last_half_reg     <= last_half_next;
            cur_pixel_reg     <= cur_pixel_next;
            cur_half_reg      <= cur_half_next;
            second_reg        <= second_next;
            slot_reg          <= slot_next;
            colour_reg        <= colour_next;
        end
    end

    // a result is only launched into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.emit_word || dp_cmd.emit_zero || dp_cmd.emit_reply) |-> status.out_free)
        else $error("result launched into a busy output register");

    a_emit_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dp_cmd.emit_word, dp_cmd.emit_zero, dp_cmd.emit_reply}))
        else $error("more than one result kind launched");

    // the pixel pointer stays inside the store outside the reset code
    a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
        !in_reset_code_reg |-> ({1'b0, next_pixel_reg} < PIX_LIMIT))
        else $error("next pixel beyond the store");

    a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_reset_code_reg |-> (progress_reg != {CFG_DATA_W{1'b1}}))
        else $error("reset code count overflow");

    // the second pixel of a start always goes to the second half
    a_start_second: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(second_reg) |-> (cur_half_reg && state_reg == S_FETCH))
        else $error("second start pixel not routed to the second half");

endmodule

// ----- dv/led_refill_checker.sv -----
`timescale 1ns / 1ps

// watches the command, result and register channels, keeps its own copy of the
// pixel store and refill state, and compares every result transfer in order
module led_refill_checker #(
    parameter int PIXELS = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    alpr_item_if   item,
    alpr_result_if result,
    alpr_cfg_if    cfg,
    output int     failures,
    output int     outstanding,
    output int     compared
);
    import alpr_pkg::*;

    // pixel store copy
    logic [COLOUR_W-1:0] red_mem   [PIXELS];
    logic [COLOUR_W-1:0] green_mem [PIXELS];
    logic [COLOUR_W-1:0] blue_mem  [PIXELS];
    logic [BRI_W-1:0]    bri_mem   [PIXELS];

    // refill sequencing and register copies
    int unsigned           next_px;
    bit                    sending_reset_code;
    int unsigned           zero_refills;
    logic                  last_filled_half;
    logic [CFG_DATA_W-1:0] period_reg;
    logic [CFG_DATA_W-1:0] reset_len_reg;

    // results owed by accepted commands, oldest first
    out_item_t due_outputs [$];
    out_item_t burst [48];
    int        burst_len;

    function automatic void restore_defaults();
        for (int i = 0; i < PIXELS; i++) begin
            {red_mem[i], green_mem[i], blue_mem[i]} = RGB_RST;
            bri_mem[i] = BRI_RST;
        end
        next_px            = START_NEXT_PIXEL;
        sending_reset_code = 1'b0;
        zero_refills       = 0;
        last_filled_half   = 1'b1;
        period_reg         = BIT_PERIOD_RST;
        reset_len_reg      = RESET_REFILLS_RST;
    endfunction

    function automatic void add_word(int unsigned duty, logic half, int unsigned slot);
        out_item_t word;
        word          = '0;
        word.duty     = DUTY_W'(duty);
        word.out_half = half;
        word.slot     = SLOT_W'(slot);
        burst[burst_len] = word;
        burst_len++;
    endfunction

    // 24 duty words of one pixel, msb first, red then green then blue
    function automatic void add_pixel(int unsigned px, logic half);
        int unsigned period;
        int unsigned level;
        int unsigned scaled;
        if (px >= PIXELS)
            return;
        period = period_reg;
        for (int c = 0; c < 3; c++) begin
            level  = (c == COL_RED) ? red_mem[px] :
                     (c == COL_GREEN) ? green_mem[px] : blue_mem[px];
            scaled = level * bri_mem[px] / 100;
            for (int b = 7; b >= 0; b--)
                add_word(((scaled >> b) & 1) ? period * 3 / 4 : period / 4,
                         half, c * 8 + 7 - b);
        end
    endfunction

    function automatic void apply_command(cmd_t cmd, logic [PIX_W-1:0] idx,
                                          item_data_t data, logic half);
        out_item_t entry;
        burst_len = 0;
        case (cmd)
            CMD_SET_COLOUR:
                if (idx < PIXELS) begin
                    red_mem[idx]   = data.red;
                    green_mem[idx] = data.green;
                    blue_mem[idx]  = data.blue;
                end
            CMD_SET_BRIGHTNESS:
                if (idx < PIXELS && data.brightness <= BRI_MAX)
                    bri_mem[idx] = BRI_W'(data.brightness);
            CMD_READ_PIXEL:
            begin
                entry      = '0;
                entry.kind = 1'b1;
                if (idx < PIXELS) begin
                    entry.read_red        = red_mem[idx];
                    entry.read_green      = green_mem[idx];
                    entry.read_blue       = blue_mem[idx];
                    entry.read_brightness = bri_mem[idx];
                end
                burst[0]  = entry;
                burst_len = 1;
            end
            CMD_START:
            begin
                next_px            = START_NEXT_PIXEL;
                sending_reset_code = 1'b0;
                last_filled_half   = 1'b1;
                add_pixel(PIXEL_FIRST, 1'b0);
                add_pixel(PIXEL_SECOND, 1'b1);
            end
            CMD_REFILL:
                // a refill of the half filled last time does nothing
                if (half != last_filled_half) begin
                    last_filled_half = half;
                    if (!sending_reset_code) begin
                        add_pixel(next_px, half);
                        next_px++;
                        if (next_px >= PIXELS) begin
                            sending_reset_code = 1'b1;
                            zero_refills       = 0;
                        end
                    end else begin
                        // two zero halves, then silent refills
                        if (zero_refills < ZERO_HALVES)
                            for (int s = FIRST_SLOT; s <= LAST_SLOT; s++)
                                add_word(0, half, s);
                        zero_refills++;
                        if (zero_refills >= reset_len_reg) begin
                            next_px            = PIXEL_FIRST;
                            sending_reset_code = 1'b0;
                        end
                    end
                end
            default: ;
        endcase
        for (int i = 0; i < burst_len; i++) begin
            entry      = burst[i];
            entry.last = (i == burst_len - 1);
            due_outputs.push_back(entry);
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // transfers at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        item_data_t data;
        if (!rst_n) begin
            restore_defaults();
            due_outputs.delete();
            failures = 0;
            compared = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_BIT_PERIOD:    period_reg    = cfg.data;
                    CFG_RESET_REFILLS: reset_len_reg = cfg.data;
                    default: ;
                endcase
            end
            if (result.valid && result.ready) begin
                if (due_outputs.size() == 0) begin
                    $error("result transfer with nothing expected");
                    failures++;
                end else begin
                    want = due_outputs.pop_front();
                    compared++;
                    check_field("kind", want.kind, result.kind);
                    check_field("duty", want.duty, result.duty);
                    check_field("out_half", want.out_half, result.out_half);
                    check_field("slot", want.slot, result.slot);
                    check_field("last", want.last, result.last);
                    check_field("read_red", want.read_red, result.read_red);
                    check_field("read_green", want.read_green, result.read_green);
                    check_field("read_blue", want.read_blue, result.read_blue);
                    check_field("read_brightness", want.read_brightness,
                                result.read_brightness);
                end
            end
            if (item.valid && item.ready) begin
                data.red        = item.red_in;
                data.green      = item.green_in;
                data.blue       = item.blue_in;
                data.brightness = item.brightness_in;
                apply_command(cmd_t'(item.command), item.pixel_index, data,
                              item.buffer_half);
            end
        end
        outstanding = due_outputs.size();
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import alpr_pkg::*;

    localparam int PIXELS         = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 80;
    localparam int PHASE_ITEMS    = 101;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(CMD_REFILL + 1);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    alpr_item_if   item_bus ();
    alpr_result_if result_bus ();
    alpr_cfg_if    cfg_bus ();

    int   failures;
    int   outstanding;
    int   compared;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   items_sent;
    int   quiet_cycles;
    logic tb_half;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    addressable_led_pwm_refill_top #(
        .PIXEL_COUNT (PIXELS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    led_refill_checker #(
        .PIXELS (PIXELS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_bus),
        .result      (result_bus),
        .cfg         (cfg_bus),
        .failures    (failures),
        .outstanding (outstanding),
        .compared    (compared)
    );

    // receiver stalls
    always @(negedge clk)
    begin
        result_bus.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_command(logic [CMD_W-1:0] cmd, logic [PIX_W-1:0] idx,
                                logic [COLOUR_W-1:0] r, logic [COLOUR_W-1:0] g,
                                logic [COLOUR_W-1:0] b, logic [BRIN_W-1:0] bri,
                                logic half);
        while ($urandom_range(99) < send_idle_pct) begin
            item_bus.valid = 1'b0;
            @(negedge clk);
        end
        item_bus.command       = cmd;
        item_bus.pixel_index   = idx;
        item_bus.red_in        = r;
        item_bus.green_in      = g;
        item_bus.blue_in       = b;
        item_bus.brightness_in = bri;
        item_bus.buffer_half   = half;
        item_bus.valid         = 1'b1;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (cmd == CMD_REFILL)
            tb_half = half;
        else if (cmd == CMD_START)
            tb_half = 1'b1;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        cfg_bus.valid = 1'b1;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // wait for every owed result, then let any set command finish
    task automatic settle();
        item_bus.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (HOLD_OFF) @(negedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_index();
        if ($urandom_range(9) != 0)
            return PIX_W'($urandom_range(PIXELS - 1));
        return PIX_W'($urandom_range(1023));
    endfunction

    // mostly alternating refills, with stray commands and broken refills mixed in
    task automatic random_command();
        int                  roll;
        logic [CMD_W-1:0]    cmd;
        logic [BRIN_W-1:0]   bri;
        logic                half;
        roll = $urandom_range(99);
        bri  = ($urandom_range(4) != 0) ? BRIN_W'($urandom_range(100))
                                        : BRIN_W'($urandom_range(255));
        half = 1'($urandom_range(1));
        if (roll < 70) begin
            cmd  = CMD_REFILL;
            half = ~tb_half;
        end else if (roll < 74) begin
            cmd  = CMD_REFILL;
            half = tb_half;
        end else if (roll < 82)
            cmd = CMD_SET_COLOUR;
        else if (roll < 88)
            cmd = CMD_SET_BRIGHTNESS;
        else if (roll < 97)
            cmd = CMD_READ_PIXEL;
        else if (roll < 98)
            cmd = CMD_START;
        else
            cmd = CMD_SPARE_FIRST + CMD_W'($urandom_range(2));
        send_command(cmd, pick_index(), COLOUR_W'($urandom_range(255)),
                     COLOUR_W'($urandom_range(255)), COLOUR_W'($urandom_range(255)),
                     bri, half);
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] period, logic [CFG_DATA_W-1:0] reset_len,
                             int s_pct, int r_pct);
        settle();
        write_reg(CFG_BIT_PERIOD, period);
        write_reg(CFG_RESET_REFILLS, reset_len);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (PHASE_ITEMS) random_command();
    endtask

    initial
    begin
        item_bus.valid         = 1'b0;
        item_bus.command       = CMD_SET_COLOUR;
        item_bus.pixel_index   = '0;
        item_bus.red_in        = '0;
        item_bus.green_in      = '0;
        item_bus.blue_in       = '0;
        item_bus.brightness_in = '0;
        item_bus.buffer_half   = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = CFG_BIT_PERIOD;
        cfg_bus.data           = '0;
        result_bus.ready       = 1'b0;
        send_idle_pct          = 34;
        recv_idle_pct          = 54;
        items_sent             = 0;
        quiet_cycles           = 0;
        tb_half                = 1'b1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // store after reset, in range and out of range
        send_command(CMD_READ_PIXEL, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_command(CMD_READ_PIXEL, PIX_W'(PIXELS - 1), 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_command(CMD_READ_PIXEL, 10'd1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // refills before any start: half 1 repeats the reset half
        send_command(CMD_REFILL, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_command(CMD_REFILL, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_command(CMD_REFILL, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        // colour and brightness extremes, ignored writes
        send_command(CMD_SET_COLOUR, 10'd0, 8'd255, 8'd0, 8'd170, 8'd0, 1'b0);
        send_command(CMD_SET_COLOUR, 10'd1, 8'd0, 8'd255, 8'd85, 8'd0, 1'b0);
        send_command(CMD_SET_COLOUR, 10'd1023, 8'd1, 8'd2, 8'd3, 8'd0, 1'b0);
        send_command(CMD_SET_COLOUR, PIX_W'(PIXELS), 8'd4, 8'd5, 8'd6, 8'd0, 1'b0);
        send_command(CMD_SET_BRIGHTNESS, 10'd0, 8'd0, 8'd0, 8'd0, 8'd100, 1'b0);
        send_command(CMD_SET_BRIGHTNESS, 10'd1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_command(CMD_SET_BRIGHTNESS, 10'd2, 8'd0, 8'd0, 8'd0, 8'd101, 1'b0);
        send_command(CMD_SET_BRIGHTNESS, 10'd3, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
        send_command(CMD_SET_BRIGHTNESS, PIX_W'(PIXELS), 8'd0, 8'd0, 8'd0, 8'd10, 1'b0);
        send_command(CMD_READ_PIXEL, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_command(CMD_READ_PIXEL, 10'd1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_command(CMD_READ_PIXEL, 10'd2, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_command(CMD_READ_PIXEL, PIX_W'(PIXELS), 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        // start, then a repeated half and ordinary refills around spare codes
        send_command(CMD_START, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_command(CMD_REFILL, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_command(CMD_REFILL, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_command(CMD_SPARE_FIRST, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_command(CMD_SPARE_FIRST + 3'd1, 10'd5, 8'd9, 8'd9, 8'd9, 8'd50, 1'b1);
        send_command(CMD_SPARE_FIRST + 3'd2, 10'd6, 8'd7, 8'd7, 8'd7, 8'd20, 1'b1);
        send_command(CMD_REFILL, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);

        // random phases over register extremes and idling patterns
        run_phase(8'd4, 8'd1, 34, 54);
        run_phase(8'd255, 8'd0, 54, 34);
        run_phase(CFG_DATA_W'($urandom_range(5, 254)), CFG_DATA_W'($urandom_range(2, 6)),
                  0, 0);
        run_phase(CFG_DATA_W'($urandom_range(5, 254)), 8'd255, 0, 0);
        settle();

        $display("covered %0d commands and %0d compared results", items_sent, compared);
        $display("bit periods 4 and 255, reset code lengths 0, 1 and 255, with and without stalls");
        if (failures == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
